/* rtl/core/dfilt_pkg.sv */
// Shared types and constants of the order-preserving distinct filter.
package dfilt_pkg;

    // Depth of the small queues on either side of the scan engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int VALUE_W = 32;
    localparam int DCOUNT_W = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_new;
        logic [DCOUNT_W-1:0]       distinct_count;
        logic                      dropped_full;
        logic                      last;
    } result_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_EMIT
    } scan_state_t;

endpackage

/* rtl/core/dfilt_fifo.sv */
// Two-entry word queue used on the input and the result side of the filter.
module dfilt_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import dfilt_pkg::*;

    logic [WIDTH-1:0]   slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] fill_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (fill_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/dfilt_scan.sv */
// Scan engine: holds the table of distinct values and classifies each word.
module dfilt_scan #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dfilt_pkg::item_t  in_item,
    input  logic              in_empty,
    output logic              in_pop,
    output dfilt_pkg::result_t res,
    output logic              res_push,
    input  logic              res_full
);
    import dfilt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] table_mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    scan_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    item_t              cur_reg, cur_next;
    logic               found_reg, found_next;

    logic               fresh;
    logic               room;
    logic               stored;
    logic [CNT_W-1:0]   cnt_after;

    assign fresh     = ~found_reg;
    assign room      = (cnt_reg < CNT_W'(CAPACITY));
    assign stored    = fresh & room;
    assign cnt_after = cnt_reg + CNT_W'(stored);
    assign wr_addr   = cnt_reg[IDX_W-1:0];

    // The result is formed from registers; it is pushed only in the emit state.
    assign res.value          = cur_reg.value;
    assign res.is_new         = fresh;
    assign res.distinct_count = DCOUNT_W'(cnt_after);
    assign res.dropped_full   = fresh & ~room;
    assign res.last           = cur_reg.last;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= cur_reg.value;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        found_next = found_reg;
        rd_addr    = '0;
        in_pop     = 1'b0;
        res_push   = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            SCAN_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop     = 1'b1;
                    cur_next   = in_item;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = (cnt_reg == '0) ? SCAN_EMIT : SCAN_RUN;
                end
            end
            SCAN_RUN:
            begin
                // rd_data_reg holds the entry at idx_reg, registered from the table read of the cycle before.
                if (rd_data_reg == cur_reg.value)
                begin
                    found_next = 1'b1;
                    state_next = SCAN_EMIT;
                end
                else if (CNT_W'(idx_reg) + 1'b1 == cnt_reg)
                begin
                    state_next = SCAN_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            SCAN_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    wr_en      = stored;
                    cnt_next   = cur_reg.last ? '0 : cnt_after;
                    state_next = SCAN_IDLE;
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("stored count exceeds the table capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN_RUN) |-> (CNT_W'(idx_reg) < cnt_reg))
        else $error("scan index reached past the stored entries");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!res_full && state_reg == SCAN_EMIT))
        else $error("result pushed without room or outside the emit state");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && cur_reg.last) |=> (cnt_reg == '0))
        else $error("table not emptied after the final word of a set");

    a_repeat_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && found_reg && !cur_reg.last) |=> $stable(cnt_reg))
        else $error("repeat word changed the stored count");

endmodule

/* rtl/core/order_preserving_dedup_filter.sv */
// Top level: input queue, table scan engine and result queue.
// Path: an accepted word waits in the input queue, the scan engine compares it with the N
// distinct values stored in the current set (0 to CAPACITY), and its result goes to the
// result queue; a repeat ends the scan early, and a full result queue holds the result.
// The scan engine takes a new word only once the result of the last one is pushed; its
// table scan reads one stored entry per cycle from the table memory.
// Reset: both queues empty and the stored count zero; table contents are not cleared.
module order_preserving_dedup_filter #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] value_out,
    output logic               is_new,
    output logic [6:0]         distinct_count,
    output logic               dropped_full,
    output logic               last_out
);
    import dfilt_pkg::*;

    item_t   in_word;
    item_t   scan_item;
    logic    scan_empty;
    logic    scan_pop;
    result_t scan_res;
    logic    res_push;
    logic    res_full;
    result_t out_word;

    assign in_word.value = value;
    assign in_word.last  = last;

    dfilt_fifo #(
        .WIDTH ($bits(item_t))
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_word),
        .full  (full),
        .pop   (scan_pop),
        .rdata (scan_item),
        .empty (scan_empty)
    );

    dfilt_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (scan_item),
        .in_empty (scan_empty),
        .in_pop   (scan_pop),
        .res      (scan_res),
        .res_push (res_push),
        .res_full (res_full)
    );

    dfilt_fifo #(
        .WIDTH ($bits(result_t))
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (scan_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_word),
        .empty (empty)
    );

    assign value_out      = out_word.value;
    assign is_new         = out_word.is_new;
    assign distinct_count = out_word.distinct_count;
    assign dropped_full   = out_word.dropped_full;
    assign last_out       = out_word.last;

endmodule

/* tb/dfilt_result_checker.sv */
`timescale 1ns / 100ps
// Checker for the distinct filter: predicts each result word and compares it at the result port.
module dfilt_result_checker #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [31:0] value,
    input  logic               last,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] value_out,
    input  logic               is_new,
    input  logic [6:0]         distinct_count,
    input  logic               dropped_full,
    input  logic               last_out,
    output int                 errors,
    output int                 pending
);
    import dfilt_pkg::*;

    logic [VALUE_W-1:0] seen_table [CAPACITY];
    int unsigned        seen_count = 0;
    int                 fail_count = 0;
    result_t            expected_results [$];

    // Works out the result of one accepted word and updates the table.
    function automatic result_t filter_word(logic signed [31:0] v, logic l);
        result_t r;
        logic    found;
        found = 1'b0;
        for (int i = 0; i < seen_count; i++)
        begin
            if (seen_table[i] == v)
                found = 1'b1;
        end
        r.value = v;
        r.is_new = !found;
        r.dropped_full = 1'b0;
        if (!found)
        begin
            if (seen_count < CAPACITY)
            begin
                seen_table[seen_count] = v;
                seen_count++;
            end
            else
                r.dropped_full = 1'b1;
        end
        r.distinct_count = DCOUNT_W'(seen_count);
        r.last = l;
        // The table empties after the word that closes a set.
        if (l)
            seen_count = 0;
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (push && !full)
                expected_results.push_back(filter_word(value, last));
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual value %0h",
                             $time, value_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("value_out", want.value, value_out);
                    check_field("is_new", 32'(want.is_new), 32'(is_new));
                    check_field("distinct_count", 32'(want.distinct_count),
                                32'(distinct_count));
                    check_field("dropped_full", 32'(want.dropped_full), 32'(dropped_full));
                    check_field("last_out", 32'(want.last), 32'(last_out));
                end
            end
        end
        errors <= fail_count;
        pending <= expected_results.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives sets of values into the distinct filter and gives the verdict.
module tb;

    localparam int CAPACITY = 64;
    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] value = '0;
    logic               last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] value_out;
    logic               is_new;
    logic [6:0]         distinct_count;
    logic               dropped_full;
    logic               last_out;
    int                 errors;
    int                 pending;

    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 sent_words = 0;
    int                 pop_mode = 0;
    int                 pop_span = 0;

    always #5 clk = ~clk;

    order_preserving_dedup_filter #(.CAPACITY(CAPACITY)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .value          (value),
        .last           (last),
        .empty          (empty),
        .pop            (pop),
        .value_out      (value_out),
        .is_new         (is_new),
        .distinct_count (distinct_count),
        .dropped_full   (dropped_full),
        .last_out       (last_out)
    );

    dfilt_result_checker #(.CAPACITY(CAPACITY)) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .value          (value),
        .last           (last),
        .empty          (empty),
        .pop            (pop),
        .value_out      (value_out),
        .is_new         (is_new),
        .distinct_count (distinct_count),
        .dropped_full   (dropped_full),
        .last_out       (last_out),
        .errors         (errors),
        .pending        (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL order_preserving_dedup_filter");
            $finish;
        end
    end

    // The receiver switches between free flow, random stalls and long stalls.
    always @(posedge clk)
    begin
        if (pop_span == 0)
        begin
            pop_mode = $urandom_range(0, 3);
            pop_span = $urandom_range(10, 200);
        end
        pop_span--;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (pop_span % 16 == 0);
        endcase
    end

    // Sends one word in bursts; returns at the edge where it is accepted.
    task automatic send_word(input logic signed [31:0] v, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        push <= 1'b1;
        value <= v;
        last <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
        sent_words++;
    endtask

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        else if (sel < 3)
            return $signed($urandom_range(0, 15)) - 32'sd8;
        return $urandom;
    endfunction

    // A short set draws from a small pool so repeats are common.
    task automatic short_set();
        logic signed [31:0] pool [$];
        int                 len;
        int                 pool_size;
        pool_size = $urandom_range(1, 10);
        len = $urandom_range(1, 16);
        for (int i = 0; i < pool_size; i++)
            pool.push_back(pick_value());
        for (int i = 0; i < len; i++)
            send_word(pool[$urandom_range(0, pool_size - 1)], i == len - 1);
    endtask

    // A long set fills the table, then mixes stored and dropped values.
    task automatic filling_set();
        logic signed [31:0] pool [$];
        int                 len;
        int                 pool_size;
        pool_size = $urandom_range(CAPACITY, CAPACITY + 8);
        len = pool_size + $urandom_range(0, 20);
        for (int i = 0; i < pool_size; i++)
            pool.push_back($urandom);
        for (int i = 0; i < len; i++)
            send_word(i < pool_size ? pool[i] : pool[$urandom_range(0, pool_size - 1)],
                      i == len - 1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme values, repeats of them, and a set closing on a repeat.
        send_word(VAL_MIN, 1'b0);
        send_word(VAL_MAX, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(VAL_MIN, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b1);
        // One-word set, then a set whose first value was seen in the previous set.
        send_word(VAL_MAX, 1'b1);
        send_word(VAL_MAX, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b1);
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shaaaa_aaaa, 1'b0);
        send_word(32'sh5555_5555, 1'b1);

        sent_words = 0;
        while (sent_words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 19) == 0)
                filling_set();
            else
                short_set();
        end
        push <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS order_preserving_dedup_filter");
        else
            $display("FAIL order_preserving_dedup_filter");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dfilt_pkg.sv
rtl/core/dfilt_fifo.sv
rtl/core/dfilt_scan.sv
rtl/core/order_preserving_dedup_filter.sv
tb/dfilt_result_checker.sv
tb/tb.sv
